// ===== rtl/lbcl_pkg.sv =====
// shared types and constants for the load blink-code led driver
package lbcl_pkg;

   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned TenthsWidth = 10;
   localparam int unsigned LevelWidth  = 3;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [TenthsWidth-1:0] OverloadTenths = 10'd950;
   localparam logic [TenthsWidth-1:0] Level4Tenths   = 10'd800;
   localparam logic [TenthsWidth-1:0] Level3Tenths   = 10'd600;
   localparam logic [TenthsWidth-1:0] Level2Tenths   = 10'd400;
   localparam logic [TenthsWidth-1:0] Level1Tenths   = 10'd200;

   localparam logic [TimeWidth-1:0] GapTimeReset = 32'd1000;
   localparam logic [TimeWidth-1:0] OnTimeReset  = 32'd150;
   localparam logic [TimeWidth-1:0] OffTimeReset = 32'd250;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_GAP_TIME = 2'd0,
      CSR_ON_TIME  = 2'd1,
      CSR_OFF_TIME = 2'd2
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ON   = 2'd1,
      PH_OFF  = 2'd2
   } phase_type;

   typedef struct packed {
      logic                   op;
      logic [TenthsWidth-1:0] load_tenths;
      logic [TimeWidth-1:0]   now_time;
   } req_type;

   typedef struct packed {
      logic led_write;
      logic led_value;
   } rsp_type;

   typedef struct packed {
      logic [TimeWidth-1:0] gap_time;
      logic [TimeWidth-1:0] on_time;
      logic [TimeWidth-1:0] off_time;
   } cfg_type;

   typedef struct packed {
      logic                  overload;
      phase_type             phase;
      logic [LevelWidth-1:0] level;
      logic [LevelWidth-1:0] index;
   } status_type;

endpackage

// ===== rtl/lbcl_csr.sv =====
// configuration registers for gap, on and off times
module lbcl_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [lbcl_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [lbcl_pkg::TimeWidth-1:0]       csr_wdata,
   output lbcl_pkg::cfg_type                    cfg
);

   lbcl_pkg::cfg_type cfg_ff;
   lbcl_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            lbcl_pkg::CSR_GAP_TIME: cfg_in.gap_time = csr_wdata;
            lbcl_pkg::CSR_ON_TIME:  cfg_in.on_time  = csr_wdata;
            lbcl_pkg::CSR_OFF_TIME: cfg_in.off_time = csr_wdata;
            default:                cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_time <= lbcl_pkg::GapTimeReset;
         cfg_ff.on_time  <= lbcl_pkg::OnTimeReset;
         cfg_ff.off_time <= lbcl_pkg::OffTimeReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/lbcl_engine.sv =====
// input register, blink state and single-pass step logic
module lbcl_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  lbcl_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lbcl_pkg::req_type    req_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lbcl_pkg::rsp_type    out_data,
   output lbcl_pkg::status_type status
);

   logic                                  item_valid_ff;
   logic                                  item_valid_in;
   lbcl_pkg::req_type                     item_ff;
   logic                                  advance;

   logic                                  overload_ff;
   logic                                  overload_in;
   logic [lbcl_pkg::LevelWidth-1:0]       level_ff;
   logic [lbcl_pkg::LevelWidth-1:0]       level_in;
   logic [lbcl_pkg::LevelWidth-1:0]       index_ff;
   logic [lbcl_pkg::LevelWidth-1:0]       index_in;
   lbcl_pkg::phase_type                   phase_ff;
   lbcl_pkg::phase_type                   phase_in;
   logic [lbcl_pkg::TimeWidth-1:0]        start_ff;
   logic [lbcl_pkg::TimeWidth-1:0]        start_in;

   logic [lbcl_pkg::TimeWidth-1:0]        elapsed;
   logic [lbcl_pkg::LevelWidth-1:0]       new_level;
   logic                                  wr;
   logic                                  val;

   assign advance       = item_valid_ff && out_ready;
   assign req_ready     = !item_valid_ff || out_ready;
   assign item_valid_in = (req_valid && req_ready) || (item_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   // load quantizer
   always_comb begin
      if (item_ff.load_tenths >= lbcl_pkg::Level4Tenths) begin
         new_level = 3'd4;
      end else if (item_ff.load_tenths >= lbcl_pkg::Level3Tenths) begin
         new_level = 3'd3;
      end else if (item_ff.load_tenths >= lbcl_pkg::Level2Tenths) begin
         new_level = 3'd2;
      end else if (item_ff.load_tenths >= lbcl_pkg::Level1Tenths) begin
         new_level = 3'd1;
      end else begin
         new_level = 3'd0;
      end
   end

   assign elapsed = item_ff.now_time - start_ff;

   always_comb begin
      overload_in = overload_ff;
      level_in    = level_ff;
      index_in    = index_ff;
      phase_in    = phase_ff;
      start_in    = start_ff;
      wr          = 1'b0;
      val         = 1'b0;
      if (item_ff.op == lbcl_pkg::OP_LOAD) begin
         if (item_ff.load_tenths >= lbcl_pkg::OverloadTenths) begin
            overload_in = 1'b1;
            wr          = 1'b1;
            val         = 1'b1;
         end else if (!overload_ff && (new_level != level_ff)) begin
            level_in = new_level;
            index_in = '0;
            phase_in = lbcl_pkg::PH_IDLE;
            start_in = item_ff.now_time;
         end
      end else if (!overload_ff) begin
         case (phase_ff)
            lbcl_pkg::PH_ON: begin
               if (elapsed >= cfg.on_time) begin
                  phase_in = lbcl_pkg::PH_OFF;
                  start_in = item_ff.now_time;
                  wr       = 1'b1;
               end
            end
            lbcl_pkg::PH_OFF: begin
               if (elapsed >= cfg.off_time) begin
                  start_in = item_ff.now_time;
                  wr       = 1'b1;
                  if (index_ff < level_ff) begin
                     index_in = index_ff + 3'd1;
                     phase_in = lbcl_pkg::PH_ON;
                     val      = 1'b1;
                  end else begin
                     index_in = '0;
                     phase_in = lbcl_pkg::PH_IDLE;
                  end
               end
            end
            default: begin
               wr = 1'b1;
               if ((level_ff != '0) && ((start_ff == '0) || (elapsed >= cfg.gap_time))) begin
                  phase_in = lbcl_pkg::PH_ON;
                  start_in = item_ff.now_time;
                  index_in = 3'd1;
                  val      = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overload_ff <= 1'b0;
         level_ff    <= '0;
         index_ff    <= '0;
         phase_ff    <= lbcl_pkg::PH_IDLE;
         start_ff    <= '0;
      end else if (advance) begin
         overload_ff <= overload_in;
         level_ff    <= level_in;
         index_ff    <= index_in;
         phase_ff    <= phase_in;
         start_ff    <= start_in;
      end
   end

   assign out_valid          = item_valid_ff;
   assign out_data.led_write = wr;
   assign out_data.led_value = wr & val;

   assign status.overload = overload_ff;
   assign status.phase    = phase_ff;
   assign status.level    = level_ff;
   assign status.index    = index_ff;

endmodule

// ===== rtl/lbcl_out.sv =====
// result register towards the rsp channel
module lbcl_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  lbcl_pkg::rsp_type in_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lbcl_pkg::rsp_type rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   lbcl_pkg::rsp_type data_ff;

   assign in_ready = !valid_ff || rsp_ready;
   assign valid_in = in_valid || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/load_blink_code_led_top.sv =====
// top level of the load blink-code led driver
// path: an accepted item is held in the engine input register, and its result is
// then captured in the result register, which drives the rsp channel
// throughput: one item per cycle while rsp_ready is high, set by the combinational
// step between the input register and the result register
// reset: synchronous, clears the blink state and the overload latch, empties both
// register stages; configuration returns to gap 1000, on 150, off 250 ms
module load_blink_code_led_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  lbcl_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output lbcl_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [lbcl_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [lbcl_pkg::TimeWidth-1:0]       csr_wdata
);

   lbcl_pkg::cfg_type    cfg;
   lbcl_pkg::rsp_type    step_data;
   lbcl_pkg::status_type status;
   logic                 step_valid;
   logic                 step_ready;

   lbcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lbcl_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_valid (step_valid),
      .out_ready (step_ready),
      .out_data  (step_data),
      .status    (status)
   );

   lbcl_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step_valid),
      .in_ready  (step_ready),
      .in_data   (step_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // overload latch only clears on reset
   a_latch_holds: assert property (@(posedge clock) disable iff (reset)
      status.overload |=> status.overload)
      else $error("overload latch dropped");

   // idle always leaves the blink index at zero
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      (status.phase == lbcl_pkg::PH_IDLE) |-> (status.index == '0))
      else $error("blink index not cleared in idle");

   // a blink group only runs with a nonzero level
   a_active_level: assert property (@(posedge clock) disable iff (reset)
      (status.phase != lbcl_pkg::PH_IDLE) |-> (status.level != '0))
      else $error("blink phase active at level zero");

   // a lit result can only follow once the led is written
   a_value_qualified: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.led_write) |-> !rsp_data.led_value)
      else $error("led value set without led write");

endmodule
